// File: rtl/core/nat_pkg.sv
// Shared types, constants and register map of the note actuator timer bank.
// No dependencies; every module of the block refers here by scoped names.
package nat_pkg;

    // channel counts
    localparam int MAGNET_CHANNELS = 24;
    localparam int SERVO_CHANNELS  = 6;

    // field widths
    localparam int MAG_OUT_W   = 24;
    localparam int NOTE_W      = 5;
    localparam int LEN_W       = 5;
    localparam int EIGHTH_W    = 11;
    localparam int DUTY_W      = 14;
    localparam int COUNT_W     = 16;
    localparam int MAG_IDX_W   = 5;
    localparam int SERVO_IDX_W = 3;
    localparam int POS_W       = 3;

    // only the lowest magnets show on the output mask
    localparam int MASK_CHANNELS =
        (MAGNET_CHANNELS < MAG_OUT_W) ? MAGNET_CHANNELS : MAG_OUT_W;

    // note layout
    localparam int NOTES_PER_GROUP   = 5;
    localparam int MAGNETS_PER_GROUP = 4;
    localparam int NOTE_GROUPS       = 6;
    localparam int LAST_NOTE         = 30;

    // input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_NOTE = 1'b1;

    // register map (word index in paddr[3:2])
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_EIGHTH      = 2'd0;
    localparam logic [1:0] REG_DUTY_LEFT   = 2'd1;
    localparam logic [1:0] REG_DUTY_RIGHT  = 2'd2;

    // register reset values
    localparam logic [EIGHTH_W-1:0] EIGHTH_RESET = 11'd250;
    localparam logic [DUTY_W-1:0]   LEFT_RESET   = 14'd819;
    localparam logic [DUTY_W-1:0]   RIGHT_RESET  = 14'd1638;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic              mode;
        logic [NOTE_W-1:0] note_number;
        logic [LEN_W-1:0]  length_eighths;
    } t_in_item;

    typedef struct packed {
        logic [MAG_OUT_W-1:0]   magnets_on;
        logic                   servo_update;
        logic [SERVO_IDX_W-1:0] servo_index;
        logic [DUTY_W-1:0]      servo_duty;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic                   is_tick;
        logic                   arm;
        logic [MAG_IDX_W-1:0]   magnet_idx;
        logic [COUNT_W-1:0]     load_val;
        logic                   servo_upd;
        logic [SERVO_IDX_W-1:0] servo_idx;
    } t_cmd;

    // queue handshake seen by the front
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    // queue handshake seen by the back
    typedef struct packed {
        logic nonempty;
        logic pop;
    } t_q_rd;

endpackage

// File: rtl/core/nat_front.sv
// Front stage: accepts requests, decodes the note into group, magnet and servo
// and computes the countdown load. Depends on nat_pkg.
module nat_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  nat_pkg::t_in_item                i_item,
    input  logic [nat_pkg::EIGHTH_W-1:0]     i_eighth_ticks,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output nat_pkg::t_cmd                    o_cmd
);

    logic          r_valid;
    nat_pkg::t_cmd r_cmd;
    nat_pkg::t_cmd n_cmd;
    logic          advance;

    logic                              note_ok;
    logic [nat_pkg::NOTE_W-1:0]        note_m1;
    logic [nat_pkg::SERVO_IDX_W-1:0]   group;
    logic [nat_pkg::POS_W-1:0]         pos;
    logic [nat_pkg::MAG_IDX_W-1:0]     mag_idx;
    logic [nat_pkg::NOTE_W-1:0]        group_base;

    // decode the note
    always_comb begin
        note_ok = (i_item.note_number >= nat_pkg::NOTE_W'(1))
                  && (i_item.note_number <= nat_pkg::NOTE_W'(nat_pkg::LAST_NOTE));
        note_m1 = i_item.note_number - nat_pkg::NOTE_W'(1);
        group   = '0;
        for (int k = 1; k < nat_pkg::NOTE_GROUPS; k++) begin
            if (note_m1 >= nat_pkg::NOTE_W'(k * nat_pkg::NOTES_PER_GROUP)) begin
                group = nat_pkg::SERVO_IDX_W'(k);
            end
        end
        group_base = nat_pkg::NOTE_W'(group * nat_pkg::NOTE_W'(nat_pkg::NOTES_PER_GROUP));
        pos        = nat_pkg::POS_W'(note_m1 - group_base);
        mag_idx    = nat_pkg::MAG_IDX_W'(
                        group * nat_pkg::MAG_IDX_W'(nat_pkg::MAGNETS_PER_GROUP))
                     + nat_pkg::MAG_IDX_W'(pos) - nat_pkg::MAG_IDX_W'(1);
    end

    // build the classified request
    always_comb begin
        n_cmd            = '0;
        n_cmd.is_tick    = (i_item.mode == nat_pkg::MODE_TICK);
        n_cmd.magnet_idx = mag_idx;
        n_cmd.servo_idx  = group;
        // 5 x 11 bit product never exceeds 16 bits
        n_cmd.load_val   = nat_pkg::COUNT_W'(i_item.length_eighths)
                           * nat_pkg::COUNT_W'(i_eighth_ticks);
        if (i_item.mode == nat_pkg::MODE_NOTE && note_ok) begin
            // open string (first note of a group) arms nothing
            n_cmd.arm       = (pos != '0)
                              && ({1'b0, mag_idx} < (nat_pkg::MAG_IDX_W + 1)'(
                                     nat_pkg::MAGNET_CHANNELS));
            n_cmd.servo_upd = ({1'b0, group} < (nat_pkg::SERVO_IDX_W + 1)'(
                                  nat_pkg::SERVO_CHANNELS));
        end
    end

    // stage register moves when empty or when the queue takes it
    assign advance  = !r_valid || !i_q_full;
    assign o_stall  = !advance;
    assign o_q_push = r_valid && !i_q_full;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/core/nat_queue.sv
// Short request queue between the front and back stages.
// Depends on nat_pkg for the request type and depth.
module nat_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nat_pkg::t_cmd i_cmd,
    input  logic          i_push,
    output logic          o_full,
    output nat_pkg::t_cmd o_head,
    output logic          o_nonempty,
    input  logic          i_pop
);

    nat_pkg::t_cmd                 r_mem [nat_pkg::QUEUE_DEPTH];
    logic [nat_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [nat_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [nat_pkg::QPTR_W:0]      r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full     = (r_count == (nat_pkg::QPTR_W + 1)'(nat_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + nat_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + nat_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (nat_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (nat_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/nat_back.sv
// Back stage: magnet countdowns, servo positions and the output register.
// Depends on nat_pkg.
module nat_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nat_pkg::t_cmd                i_cmd,
    input  logic                         i_q_nonempty,
    output logic                         o_q_pop,
    input  logic [nat_pkg::DUTY_W-1:0]   i_duty_left,
    input  logic [nat_pkg::DUTY_W-1:0]   i_duty_right,
    output logic                         o_valid,
    input  logic                         i_stall,
    output nat_pkg::t_out_item           o_item
);

    logic [nat_pkg::COUNT_W-1:0] r_count [nat_pkg::MAGNET_CHANNELS];
    logic [nat_pkg::COUNT_W-1:0] n_count [nat_pkg::MAGNET_CHANNELS];
    logic                        r_right [nat_pkg::SERVO_CHANNELS];
    logic                        n_right [nat_pkg::SERVO_CHANNELS];
    logic                        r_valid;
    nat_pkg::t_out_item          r_item;
    nat_pkg::t_out_item          n_item;
    logic                        pop;

    assign pop     = i_q_nonempty && (!r_valid || !i_stall);
    assign o_q_pop = pop;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // per-channel countdown update
    always_comb begin
        for (int i = 0; i < nat_pkg::MAGNET_CHANNELS; i++) begin
            n_count[i] = r_count[i];
            if (i_cmd.is_tick) begin
                if (r_count[i] != '0) begin
                    n_count[i] = r_count[i] - nat_pkg::COUNT_W'(1);
                end
            end else if (i_cmd.arm && i_cmd.magnet_idx == nat_pkg::MAG_IDX_W'(i)) begin
                n_count[i] = i_cmd.load_val;
            end
        end
    end

    // servo toggle and result assembly
    always_comb begin
        n_item = '0;
        for (int s = 0; s < nat_pkg::SERVO_CHANNELS; s++) begin
            n_right[s] = r_right[s];
            if (i_cmd.servo_upd && i_cmd.servo_idx == nat_pkg::SERVO_IDX_W'(s)) begin
                n_right[s]        = !r_right[s];
                n_item.servo_duty = n_right[s] ? i_duty_right : i_duty_left;
            end
        end
        n_item.servo_update = i_cmd.servo_upd;
        n_item.servo_index  = i_cmd.servo_upd ? i_cmd.servo_idx : '0;
        for (int i = 0; i < nat_pkg::MASK_CHANNELS; i++) begin
            n_item.magnets_on[i] = (n_count[i] != '0);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < nat_pkg::MAGNET_CHANNELS; i++) begin
                r_count[i] <= '0;
            end
            for (int s = 0; s < nat_pkg::SERVO_CHANNELS; s++) begin
                r_right[s] <= 1'b0;
            end
        end else if (pop) begin
            r_count <= n_count;
            r_right <= n_right;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/core/note_actuator_timer_bank.sv
// Top level of the note actuator timer bank: register file, front, queue, back.
// Depends on nat_pkg, nat_front, nat_queue and nat_back.
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_stall        nat_pkg::t_in_item
//  out       output     o_out_valid / i_out_stall      nat_pkg::t_out_item
//  config    input      psel penable pwrite pready     paddr[3:2] word, pwdata/prdata
//
// One request per cycle while the output is not stalled; a result passes the front register,
// the queue write and the output register before o_out_valid rises.
// The four-entry queue lets the front keep taking requests while the output stalls.
// Synchronous active-low reset clears countdowns and servo positions and loads the register reset values.
module note_actuator_timer_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nat_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nat_pkg::t_out_item            o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nat_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [nat_pkg::EIGHTH_W-1:0] r_eighth;
    logic [nat_pkg::DUTY_W-1:0]   r_left;
    logic [nat_pkg::DUTY_W-1:0]   r_right;
    logic                         wr_en;

    nat_pkg::t_q_wr q_wr;
    nat_pkg::t_q_rd q_rd;
    nat_pkg::t_cmd  front_cmd;
    nat_pkg::t_cmd  head_cmd;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eighth <= nat_pkg::EIGHTH_RESET;
            r_left   <= nat_pkg::LEFT_RESET;
            r_right  <= nat_pkg::RIGHT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                nat_pkg::REG_EIGHTH:     r_eighth <= pwdata[nat_pkg::EIGHTH_W-1:0];
                nat_pkg::REG_DUTY_LEFT:  r_left   <= pwdata[nat_pkg::DUTY_W-1:0];
                nat_pkg::REG_DUTY_RIGHT: r_right  <= pwdata[nat_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        case (paddr[3:2])
            nat_pkg::REG_EIGHTH:     prdata = 32'(r_eighth);
            nat_pkg::REG_DUTY_LEFT:  prdata = 32'(r_left);
            nat_pkg::REG_DUTY_RIGHT: prdata = 32'(r_right);
            default:                 prdata = '0;
        endcase
    end

    nat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_item         (i_in),
        .i_eighth_ticks (r_eighth),
        .i_q_full       (q_wr.full),
        .o_q_push       (q_wr.push),
        .o_cmd          (front_cmd)
    );

    nat_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (front_cmd),
        .i_push     (q_wr.push),
        .o_full     (q_wr.full),
        .o_head     (head_cmd),
        .o_nonempty (q_rd.nonempty),
        .i_pop      (q_rd.pop)
    );

    nat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_q_nonempty (q_rd.nonempty),
        .o_q_pop      (q_rd.pop),
        .i_duty_left  (r_left),
        .i_duty_right (r_right),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_item       (o_out)
    );

    // a result without a servo move carries zero index and duty
    a_no_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.servo_update) |->
            (o_out.servo_index == '0 && o_out.servo_duty == '0))
        else $error("servo fields nonzero without a servo move");

    // a reported servo is always one that exists
    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.servo_update) |->
            (o_out.servo_index < nat_pkg::SERVO_IDX_W'(nat_pkg::SERVO_CHANNELS)))
        else $error("servo index out of range");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr.full |-> !q_wr.push)
        else $error("push into full queue");

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// File: tb/nat_bank_checker.sv
// Checker for the note actuator timer bank: watches the request, result and register
// traffic, keeps its own copy of the magnet timers and servo positions, compares results.
// Depends on nat_pkg.
module nat_bank_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  nat_pkg::t_in_item           i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  nat_pkg::t_out_item          i_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [nat_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic [31:0]                 i_prdata,
    output int                          o_fail_count,
    output int                          o_waiting
);

    // shadow registers and actuator state
    logic [nat_pkg::EIGHTH_W-1:0] eighth_ticks;
    logic [nat_pkg::DUTY_W-1:0]   duty_left;
    logic [nat_pkg::DUTY_W-1:0]   duty_right;
    logic [nat_pkg::COUNT_W-1:0]  magnet_timer [nat_pkg::MAGNET_CHANNELS];
    logic                         servo_right  [nat_pkg::SERVO_CHANNELS];

    // results owed by the block, oldest first
    nat_pkg::t_out_item           owed_results [$];

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    // apply one request to the shadow state and return the result it should produce
    function automatic nat_pkg::t_out_item apply_request(nat_pkg::t_in_item req);
        nat_pkg::t_out_item res;
        int                 group;
        int                 slot;
        int                 magnet;
        int unsigned        load;
        res = '0;
        if (req.mode == nat_pkg::MODE_TICK) begin
            for (int i = 0; i < nat_pkg::MAGNET_CHANNELS; i++)
                if (magnet_timer[i] != '0)
                    magnet_timer[i] = magnet_timer[i] - 1'b1;
        end else if (req.note_number >= 1 && req.note_number <= nat_pkg::LAST_NOTE) begin
            group = (int'(req.note_number) - 1) / nat_pkg::NOTES_PER_GROUP;
            slot  = (int'(req.note_number) - 1) % nat_pkg::NOTES_PER_GROUP;
            // open string: first note of a group fires no magnet
            if (slot != 0) begin
                magnet = group * nat_pkg::MAGNETS_PER_GROUP + slot - 1;
                if (magnet < nat_pkg::MAGNET_CHANNELS) begin
                    load = 32'(req.length_eighths) * 32'(eighth_ticks);
                    if (load > 32'hFFFF)
                        load = 32'hFFFF;
                    magnet_timer[magnet] = nat_pkg::COUNT_W'(load);
                end
            end
            if (group < nat_pkg::SERVO_CHANNELS) begin
                servo_right[group] = !servo_right[group];
                res.servo_update   = 1'b1;
                res.servo_index    = nat_pkg::SERVO_IDX_W'(group);
                res.servo_duty     = servo_right[group] ? duty_right : duty_left;
            end
        end
        for (int i = 0; i < nat_pkg::MASK_CHANNELS; i++)
            res.magnets_on[i] = (magnet_timer[i] != '0);
        return res;
    endfunction

    function automatic logic [31:0] register_value(logic [1:0] word);
        case (word)
            nat_pkg::REG_EIGHTH:     return 32'(eighth_ticks);
            nat_pkg::REG_DUTY_LEFT:  return 32'(duty_left);
            nat_pkg::REG_DUTY_RIGHT: return 32'(duty_right);
            default:                 return '0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        nat_pkg::t_out_item want;
        if (!i_rst_n) begin
            eighth_ticks = nat_pkg::EIGHTH_RESET;
            duty_left    = nat_pkg::LEFT_RESET;
            duty_right   = nat_pkg::RIGHT_RESET;
            for (int i = 0; i < nat_pkg::MAGNET_CHANNELS; i++)
                magnet_timer[i] = '0;
            for (int i = 0; i < nat_pkg::SERVO_CHANNELS; i++)
                servo_right[i] = 1'b0;
            owed_results.delete();
        end else begin
            // register writes update the shadow copy, reads are checked against it
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        nat_pkg::REG_EIGHTH:
                            eighth_ticks = i_pwdata[nat_pkg::EIGHTH_W-1:0];
                        nat_pkg::REG_DUTY_LEFT:
                            duty_left    = i_pwdata[nat_pkg::DUTY_W-1:0];
                        nat_pkg::REG_DUTY_RIGHT:
                            duty_right   = i_pwdata[nat_pkg::DUTY_W-1:0];
                        default: ;
                    endcase
                end else if (i_prdata !== register_value(i_paddr[3:2])) begin
                    flag_mismatch("register readback", register_value(i_paddr[3:2]),
                                  i_prdata);
                end
            end

            // results before requests: a result never answers a request of the same edge
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("result with none expected", '0, i_out);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out.magnets_on !== want.magnets_on)
                        flag_mismatch("magnets_on", want.magnets_on, i_out.magnets_on);
                    if (i_out.servo_update !== want.servo_update)
                        flag_mismatch("servo_update", want.servo_update,
                                      i_out.servo_update);
                    if (i_out.servo_index !== want.servo_index)
                        flag_mismatch("servo_index", want.servo_index, i_out.servo_index);
                    if (i_out.servo_duty !== want.servo_duty)
                        flag_mismatch("servo_duty", want.servo_duty, i_out.servo_duty);
                end
            end

            if (i_in_valid && !i_in_stall)
                owed_results.push_back(apply_request(i_in));
        end
        o_waiting = owed_results.size();
    end

endmodule

// File: tb/note_actuator_timer_bank_test.sv
// Testbench top for the note actuator timer bank: reset, register setup, directed and
// random requests with random idling on both sides. Depends on nat_pkg and nat_bank_checker.
module note_actuator_timer_bank_test;

    localparam int PHASE_ITEMS  = 172;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BURST_AT     = 700;
    localparam int BURST_CYCLES = 120;
    localparam logic [nat_pkg::NOTE_W-1:0] PAUSE_LOW  = '0;
    localparam logic [nat_pkg::NOTE_W-1:0] PAUSE_HIGH = '1;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    nat_pkg::t_in_item           in_req    = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    nat_pkg::t_out_item          out_res;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [nat_pkg::PADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int fail_count;
    int waiting;
    int requests_sent = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    bit burst_done    = 1'b0;
    bit calm          = 1'b0;

    note_actuator_timer_bank u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    nat_bank_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off once the run is well along
    always @(posedge clk) begin
        if (burst_left > 0) begin
            out_stall  <= 1'b1;
            burst_left <= burst_left - 1;
        end else if (!burst_done && requests_sent >= BURST_AT) begin
            out_stall  <= 1'b1;
            burst_done <= 1'b1;
            burst_left <= BURST_CYCLES - 1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 8);
        end
    end

    function automatic nat_pkg::t_in_item make_req(logic mode, int note, int len);
        nat_pkg::t_in_item req;
        req.mode           = mode;
        req.note_number    = nat_pkg::NOTE_W'(note);
        req.length_eighths = nat_pkg::LEN_W'(len);
        return req;
    endfunction

    // mostly real notes and ticks, a few pauses; lengths mostly in the musical range
    function automatic nat_pkg::t_in_item random_request();
        nat_pkg::t_in_item req;
        int                pick;
        pick               = $urandom_range(99);
        req.length_eighths = ($urandom_range(3) == 0) ? nat_pkg::LEN_W'($urandom)
                                                      : nat_pkg::LEN_W'($urandom_range(16));
        if (pick < 50) begin
            req.mode        = nat_pkg::MODE_TICK;
            req.note_number = nat_pkg::NOTE_W'($urandom);
        end else begin
            req.mode = nat_pkg::MODE_NOTE;
            if (pick < 95)
                req.note_number = nat_pkg::NOTE_W'($urandom_range(nat_pkg::LAST_NOTE, 1));
            else
                req.note_number = pick[0] ? PAUSE_HIGH : PAUSE_LOW;
        end
        return req;
    endfunction

    // offer one request; returns at the edge that accepts it
    task automatic send_request(input nat_pkg::t_in_item req);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    // one bus transfer; psel stays up so transfers can follow back to back
    task automatic bus_access(input logic write, input logic [1:0] word,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {word, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // write all three registers with junk above the field widths, then read them back
    task automatic set_registers(input int eighth, input int left, input int right);
        bus_access(1'b1, nat_pkg::REG_EIGHTH, ($urandom << nat_pkg::EIGHTH_W) | 32'(eighth));
        bus_access(1'b1, nat_pkg::REG_DUTY_LEFT, ($urandom << nat_pkg::DUTY_W) | 32'(left));
        bus_access(1'b1, nat_pkg::REG_DUTY_RIGHT, ($urandom << nat_pkg::DUTY_W) | 32'(right));
        bus_access(1'b0, nat_pkg::REG_EIGHTH, $urandom);
        bus_access(1'b0, nat_pkg::REG_DUTY_LEFT, $urandom);
        bus_access(1'b0, nat_pkg::REG_DUTY_RIGHT, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering and let every owed result come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        bus_access(1'b0, nat_pkg::REG_EIGHTH, '0);
        bus_access(1'b0, nat_pkg::REG_DUTY_LEFT, '0);
        bus_access(1'b0, nat_pkg::REG_DUTY_RIGHT, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);

        // directed: tick with junk fields, open strings, extremes, pauses, zero length,
        // rearming a lit magnet, then ticks
        send_request(make_req(nat_pkg::MODE_TICK, 31, 31));
        send_request(make_req(nat_pkg::MODE_NOTE, 1, 4));
        send_request(make_req(nat_pkg::MODE_NOTE, 2, 16));
        send_request(make_req(nat_pkg::MODE_NOTE, 30, 1));
        send_request(make_req(nat_pkg::MODE_NOTE, 26, 31));
        send_request(make_req(nat_pkg::MODE_NOTE, PAUSE_LOW, 5));
        send_request(make_req(nat_pkg::MODE_NOTE, PAUSE_HIGH, 7));
        send_request(make_req(nat_pkg::MODE_NOTE, 7, 0));
        send_request(make_req(nat_pkg::MODE_TICK, 0, 0));
        send_request(make_req(nat_pkg::MODE_NOTE, 2, 3));
        send_request(make_req(nat_pkg::MODE_NOTE, 3, 31));
        send_request(make_req(nat_pkg::MODE_NOTE, 4, 1));
        send_request(make_req(nat_pkg::MODE_NOTE, 5, 2));
        send_request(make_req(nat_pkg::MODE_NOTE, 6, 8));
        send_request(make_req(nat_pkg::MODE_NOTE, 29, 16));
        send_request(make_req(nat_pkg::MODE_NOTE, 1, 0));
        send_request(make_req(nat_pkg::MODE_TICK, 21, 10));
        send_request(make_req(nat_pkg::MODE_TICK, 10, 21));
        drain();

        // random phases over several register settings, extremes included
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_registers(1, 0, 16383);
                1: set_registers(2000, 16383, 0);
                2: set_registers(0, 5, 9);
                3: set_registers(2047, 1, 16382);
                4: set_registers(3, $urandom_range(16383), $urandom_range(16383));
                default: set_registers($urandom_range(8, 1), $urandom_range(16383),
                                       $urandom_range(16383));
            endcase
            // one phase runs with no idling on either side
            calm = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            drain();
            calm = 1'b0;
        end

        if (fail_count == 0 && waiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
